FILE: src/gbta_pkg.sv
// Shared types and constants for the GB2312 text layout glyph addresser.
package gbta_pkg;

  typedef struct packed {
    logic [7:0] lead_byte;
    logic [7:0] trail_byte;
  } in_word_t;

  typedef struct packed {
    logic        glyph_valid;
    logic [20:0] glyph_address;
    logic [7:0]  draw_x;
    logic [7:0]  draw_y;
    logic [1:0]  bytes_used;
    logic        page_end;
    logic        code_error;
  } out_word_t;

  // Classified character passed from the front end to the layout engine.
  typedef struct packed {
    logic        newline;
    logic        full_width;
    logic        code_error;
    logic [20:0] glyph_address;
  } glyph_cmd_t;

  typedef struct packed {
    logic [6:0] home_x;
    logic [5:0] home_y;
    logic [5:0] row_gap;
  } layout_cfg_t;

  localparam int CfgIndexW = 2;
  localparam int CfgDataW  = 7;

  localparam logic [CfgIndexW-1:0] CFG_HOME_X  = 2'd0;
  localparam logic [CfgIndexW-1:0] CFG_HOME_Y  = 2'd1;
  localparam logic [CfgIndexW-1:0] CFG_ROW_GAP = 2'd2;

  localparam logic [6:0] HOME_X_RESET  = 7'd3;
  localparam logic [5:0] HOME_Y_RESET  = 6'd1;
  localparam logic [5:0] ROW_GAP_RESET = 6'd2;

  localparam logic [7:0] NEWLINE_CODE   = 8'h0A;
  localparam logic [7:0] FULL_WIDTH_MIN = 8'hA0;

  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);

  localparam int SegCount = 11;
  localparam int SegSelW  = $clog2(SegCount);
  // Size of the table that the last segment follows, in bytes.
  localparam int LastSegOffsetBytes = 'h5400;

  localparam logic [20:0] SEG_BASE [SegCount] = '{
    21'h7FD10, 21'hBF640, 21'hE2920, 21'hE2BD0, 21'hE2C90, 21'hE2D50,
    21'hE2E60, 21'hDEEA0, 21'hBFE50, 21'h3ABF0, 21'hF6F80
  };

  // First code point of each segment except the last, which depends on glyph size.
  localparam logic [13:0] SEG_FIRST_FIXED [SegCount-1] = '{
    14'd0, 14'd110, 14'd376, 14'd470, 14'd502, 14'd564,
    14'd658, 14'd612, 14'd694, 14'd1410
  };

endpackage

FILE: src/gb2312_text_layout_glyph_addresser_top.sv
// Top level of the GB2312 text layout glyph addresser.
// Each char_word is one character of a text stream: a lead byte and a trail
// byte. A lead byte of 0x0A is a newline, a lead byte below 0xA0 a half-width
// character, anything else a full-width character that uses both bytes.
// Every accepted character gives exactly one result_word: the font ROM
// address of its glyph, the pen position where it is drawn, the bytes it
// consumed and whether the page is full afterwards.
// A word is accepted on char_valid with char_stall low; results leave on
// result_valid with result_stall low. A character is registered in the front
// register, then in the queue, then in the result register. One character is
// taken every cycle for as long as the receiver keeps taking results; the
// single pen update in the layout engine sets that rate. When the receiver
// stalls, the result is held, the four-entry queue and then the front register
// fill behind it, and then char_stall rises.
// Margins and line spacing are written on the cfg channel, which is always
// ready; a change shows at the next line or page start.
// Synchronous reset empties the pipeline, restores the default margins and
// puts the pen at the top-left start of a page.
module gb2312_text_layout_glyph_addresser_top #(
  parameter int GLYPH_BYTES   = 32,
  parameter int GLYPH_ROWS    = 16,
  parameter int GLYPH_ADVANCE = 16,
  parameter int SCREEN_W      = 131,
  parameter int SCREEN_H      = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               char_valid,
  output logic                               char_stall,
  input  gbta_pkg::in_word_t                 char_word,
  output logic                               result_valid,
  input  logic                               result_stall,
  output gbta_pkg::out_word_t                result_word,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gbta_pkg::CfgIndexW-1:0]     cfg_index,
  input  logic [gbta_pkg::CfgDataW-1:0]      cfg_data
);
  import gbta_pkg::*;

  layout_cfg_t cfg;
  logic        push;
  glyph_cmd_t  push_word;
  logic        push_ready;
  logic        pop_valid;
  glyph_cmd_t  pop_word;
  logic        pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.home_x  <= HOME_X_RESET;
      cfg.home_y  <= HOME_Y_RESET;
      cfg.row_gap <= ROW_GAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HOME_X:  cfg.home_x  <= cfg_data;
        CFG_HOME_Y:  cfg.home_y  <= cfg_data[5:0];
        CFG_ROW_GAP: cfg.row_gap <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  gbta_front #(
    .GLYPH_BYTES(GLYPH_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_word  (char_word),
    .push       (push),
    .push_word  (push_word),
    .push_ready (push_ready)
  );

  gbta_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_word  (push_word),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_word   (pop_word),
    .pop        (pop)
  );

  gbta_back #(
    .GLYPH_ROWS   (GLYPH_ROWS),
    .GLYPH_ADVANCE(GLYPH_ADVANCE),
    .SCREEN_W     (SCREEN_W),
    .SCREEN_H     (SCREEN_H)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .pop_valid    (pop_valid),
    .pop_word     (pop_word),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_word  (result_word)
  );

endmodule

FILE: src/gbta_front.sv
// Front end: takes characters, forms the code point and the font ROM address.
module gbta_front #(
  parameter int GLYPH_BYTES = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 char_valid,
  output logic                 char_stall,
  input  gbta_pkg::in_word_t   char_word,
  output logic                 push,
  output gbta_pkg::glyph_cmd_t push_word,
  input  logic                 push_ready
);
  import gbta_pkg::*;

  localparam logic [13:0] LastSegFirst = 14'(1410 + LastSegOffsetBytes / GLYPH_BYTES);

  logic               f_valid;
  logic               f_newline;
  logic               f_full;
  logic signed [14:0] f_cp;

  logic               accept;
  logic signed [14:0] lead_s;
  logic signed [14:0] trail_s;
  logic signed [14:0] cp_next;
  logic [13:0]        cp_u;
  logic [13:0]        seg_first [SegCount];
  logic [SegSelW-1:0] seg_sel;
  logic [13:0]        rel;
  logic [20:0]        addr;
  logic               err;

  assign char_stall = f_valid & ~push_ready;
  assign accept     = char_valid & ~char_stall;
  assign push       = f_valid & push_ready;

  // Half-width characters map to row 3, cell (byte - 0x20).
  always_comb begin
    lead_s  = signed'({7'd0, char_word.lead_byte});
    trail_s = signed'({7'd0, char_word.trail_byte});
    if (char_word.lead_byte < FULL_WIDTH_MIN) begin
      cp_next = 15'sd188 + lead_s - 15'sd33;
    end else begin
      cp_next = (lead_s - 15'sd161) * 15'sd94 + trail_s - 15'sd161;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (push) begin
      f_valid <= 1'b0;
    end
    if (accept) begin
      f_newline <= (char_word.lead_byte == NEWLINE_CODE);
      f_full    <= (char_word.lead_byte >= FULL_WIDTH_MIN);
      f_cp      <= cp_next;
    end
  end

  // The highest segment whose first code point is not above cp wins.
  always_comb begin
    for (int i = 0; i < SegCount - 1; i++) begin
      seg_first[i] = SEG_FIRST_FIXED[i];
    end
    seg_first[SegCount-1] = LastSegFirst;
    cp_u    = f_cp[13:0];
    seg_sel = '0;
    for (int i = 0; i < SegCount; i++) begin
      if (cp_u >= seg_first[i]) begin
        seg_sel = SegSelW'(i);
      end
    end
    rel  = cp_u - seg_first[seg_sel];
    addr = SEG_BASE[seg_sel] + 21'({7'd0, rel} * 21'(GLYPH_BYTES));
    err  = ~f_newline & f_cp[14];
  end

  always_comb begin
    push_word.newline       = f_newline;
    push_word.full_width    = f_full;
    push_word.code_error    = err;
    push_word.glyph_address = (f_newline | err) ? 21'd0 : addr;
  end

endmodule

FILE: src/gbta_queue.sv
// Short queue of classified characters between the front end and the layout engine.
module gbta_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  gbta_pkg::glyph_cmd_t push_word,
  output logic                 push_ready,
  output logic                 pop_valid,
  output gbta_pkg::glyph_cmd_t pop_word,
  input  logic                 pop
);
  import gbta_pkg::*;

  glyph_cmd_t           slots [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr;
  logic [QueuePtrW-1:0] rd_ptr;
  logic [QueuePtrW:0]   count;

  assign push_ready = (count != (QueuePtrW + 1)'(QueueDepth));
  assign pop_valid  = (count != '0);
  assign pop_word   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      slots[wr_ptr] <= push_word;
    end
  end

endmodule

FILE: src/gbta_back.sv
// Layout engine: keeps the pen position and registers one result word per character.
module gbta_back #(
  parameter int GLYPH_ROWS    = 16,
  parameter int GLYPH_ADVANCE = 16,
  parameter int SCREEN_W      = 131,
  parameter int SCREEN_H      = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  gbta_pkg::layout_cfg_t cfg,
  input  logic                  pop_valid,
  input  gbta_pkg::glyph_cmd_t  pop_word,
  output logic                  pop,
  output logic                  result_valid,
  input  logic                  result_stall,
  output gbta_pkg::out_word_t   result_word
);
  import gbta_pkg::*;

  logic [7:0] pen_x;
  logic [7:0] pen_y;
  logic       at_page_start;

  logic [7:0] pen_x_next;
  logic [7:0] pen_y_next;
  logic       at_page_start_next;
  logic       page_end;
  logic       skip;
  logic       fits_right;
  logic       fits_down;
  logic [9:0] x_adv;
  logic [9:0] y_need;

  assign pop = pop_valid & (~result_valid | ~result_stall);

  always_comb begin
    x_adv      = {2'd0, pen_x} + 10'(GLYPH_ADVANCE);
    y_need     = {2'd0, pen_y} + 10'(2 * GLYPH_ROWS) + {4'd0, cfg.row_gap};
    skip       = pop_word.newline & at_page_start;
    fits_right = ~pop_word.newline & (x_adv <= 10'(SCREEN_W - GLYPH_ADVANCE));
    fits_down  = (y_need <= 10'(SCREEN_H));

    pen_x_next         = pen_x;
    pen_y_next         = pen_y;
    at_page_start_next = 1'b0;
    page_end           = 1'b0;
    if (!skip) begin
      if (fits_right) begin
        pen_x_next = x_adv[7:0];
      end else if (fits_down) begin
        pen_x_next = {1'b0, cfg.home_x};
        pen_y_next = pen_y + 8'(GLYPH_ROWS) + {2'd0, cfg.row_gap};
      end else begin
        page_end           = 1'b1;
        pen_x_next         = {1'b0, cfg.home_x};
        pen_y_next         = {2'd0, cfg.home_y};
        at_page_start_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid  <= 1'b0;
      pen_x         <= {1'b0, HOME_X_RESET};
      pen_y         <= {2'd0, HOME_Y_RESET};
      at_page_start <= 1'b1;
    end else if (pop) begin
      result_valid  <= 1'b1;
      pen_x         <= pen_x_next;
      pen_y         <= pen_y_next;
      at_page_start <= at_page_start_next;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (pop) begin
      result_word.glyph_valid   <= ~pop_word.newline & ~pop_word.code_error;
      result_word.glyph_address <= pop_word.glyph_address;
      result_word.draw_x        <= pen_x;
      result_word.draw_y        <= pen_y;
      result_word.bytes_used    <= pop_word.full_width ? 2'd2 : 2'd1;
      result_word.page_end      <= page_end;
      result_word.code_error    <= pop_word.code_error;
    end
  end

endmodule

FILE: src/gbta_checker.sv
// Port-level checks for the glyph addresser, bound to its top level.
module gbta_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           result_valid,
  input logic                           result_stall,
  input gbta_pkg::out_word_t            result_word,
  input logic                           cfg_valid,
  input logic                           cfg_ready
);

  // A stalled result word stays in place.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result_word))
    else $error("result word changed while stalled");

  a_bytes_used: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result_word.bytes_used == 2'd1 || result_word.bytes_used == 2'd2))
    else $error("bytes_used out of range");

  a_error_no_glyph: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result_word.glyph_valid && result_word.code_error))
    else $error("glyph drawn for a bad code point");

  // Newlines and bad code points carry a zero address.
  a_no_glyph_addr: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_word.glyph_valid |-> result_word.glyph_address == 21'd0)
    else $error("address given without a glyph");

  // Configuration is never held off.
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind gb2312_text_layout_glyph_addresser_top gbta_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result_word  (result_word),
  .cfg_valid    (cfg_valid),
  .cfg_ready    (cfg_ready)
);

FILE: tb/gb2312_text_layout_glyph_addresser_top_test.sv
// Self-checking testbench for the GB2312 text layout glyph addresser.
module gb2312_text_layout_glyph_addresser_top_test;
  import gbta_pkg::*;

  localparam int GLYPH_BYTES   = 32;
  localparam int GLYPH_ROWS    = 16;
  localparam int GLYPH_ADVANCE = 16;
  localparam int SCREEN_W      = 131;
  localparam int SCREEN_H      = 64;

  localparam int SEGMENTS = 11;
  localparam int ROW_CELLS = 94;
  localparam int HALF_WIDTH_ROW = 3;
  localparam int CELL_BIAS_HALF = 'h20;
  localparam int CELL_BIAS_FULL = 'hA0;
  localparam logic [CfgIndexW-1:0] CFG_UNUSED_INDEX = 2'd3;

  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_CHARS   = 300;
  localparam int LONG_HOLD     = 60;
  localparam int END_DRAIN     = 20;
  localparam int RUN_LIMIT     = 600000;

  // Font ROM segments, searched from the last entry down.
  localparam int ROM_ORIGIN [SEGMENTS] = '{
    'h7FD10, 'hBF640, 'hE2920, 'hE2BD0, 'hE2C90, 'hE2D50,
    'hE2E60, 'hDEEA0, 'hBFE50, 'h3ABF0, 'hF6F80
  };
  localparam int ROM_FIRST_CP [SEGMENTS] = '{
    0, 110, 376, 470, 502, 564, 658, 612, 694, 1410, 1410 + 'h5400 / GLYPH_BYTES
  };

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 char_valid = 1'b0;
  logic                 char_stall;
  in_word_t             char_word = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  out_word_t            result_word;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data = '0;

  gb2312_text_layout_glyph_addresser_top dut (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_word    (char_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_word  (result_word),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin : run_limit
    #RUN_LIMIT;
    $display("status: fail");
    $finish;
  end

  // Layout state of the predictor.
  logic [6:0] margin_left;
  logic [5:0] margin_top;
  logic [5:0] line_gap;
  logic [7:0] pen_col;
  logic [7:0] pen_row;
  logic       page_fresh;

  in_word_t  pending_chars[$];
  out_word_t expected_results[$];
  int        chars_taken = 0;
  int        mismatches = 0;
  int        newline_count = 0;
  int        half_count = 0;
  int        full_count = 0;
  int        code_error_count = 0;
  int        page_end_count = 0;

  function automatic logic [20:0] glyph_rom_addr(int cp);
    for (int k = SEGMENTS - 1; k >= 0; k--) begin
      if (cp >= ROM_FIRST_CP[k])
        return 21'(ROM_ORIGIN[k] + (cp - ROM_FIRST_CP[k]) * GLYPH_BYTES);
    end
    return '0;
  endfunction

  function automatic out_word_t layout_char(in_word_t c);
    out_word_t r;
    int row, column, cp, x, y;
    logic is_newline, was_fresh, fits_right;
    r = '0;
    is_newline = (c.lead_byte == NEWLINE_CODE);
    was_fresh = page_fresh;
    x = pen_col;
    y = pen_row;
    r.draw_x = pen_col;
    r.draw_y = pen_row;
    r.bytes_used = 2'd1;
    page_fresh = 1'b0;
    // A newline right at the top of a page is swallowed without moving the pen.
    if (!(is_newline && was_fresh)) begin
      fits_right = 1'b0;
      if (!is_newline) begin
        if (c.lead_byte < FULL_WIDTH_MIN) begin
          row = HALF_WIDTH_ROW;
          column = int'(c.lead_byte) - CELL_BIAS_HALF;
        end else begin
          row = int'(c.lead_byte) - CELL_BIAS_FULL;
          column = int'(c.trail_byte) - CELL_BIAS_FULL;
          r.bytes_used = 2'd2;
        end
        cp = (row - 1) * ROW_CELLS + (column - 1);
        if (cp < 0) begin
          r.code_error = 1'b1;
        end else begin
          r.glyph_valid = 1'b1;
          r.glyph_address = glyph_rom_addr(cp);
        end
        fits_right = (x + GLYPH_ADVANCE <= SCREEN_W - GLYPH_ADVANCE);
      end
      if (fits_right) begin
        x += GLYPH_ADVANCE;
      end else if (y + 2 * GLYPH_ROWS + int'(line_gap) <= SCREEN_H) begin
        x = margin_left;
        y += GLYPH_ROWS + int'(line_gap);
      end else begin
        r.page_end = 1'b1;
        x = margin_left;
        y = margin_top;
        page_fresh = 1'b1;
      end
      pen_col = 8'(x);
      pen_row = 8'(y);
    end
    return r;
  endfunction

  // Sender: bursts of words from the pending queue with random gaps between them.
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin : char_driver
    logic      taken;
    logic      next_valid;
    in_word_t  next_word;
    out_word_t predicted;
    if (rst) begin
      char_valid <= 1'b0;
    end else begin
      taken = char_valid && !char_stall;
      next_word = char_word;
      if (taken) begin
        predicted = layout_char(char_word);
        expected_results.push_back(predicted);
        void'(pending_chars.pop_front());
        chars_taken++;
        if (char_word.lead_byte == NEWLINE_CODE) newline_count++;
        else if (char_word.lead_byte < FULL_WIDTH_MIN) half_count++;
        else full_count++;
        code_error_count += predicted.code_error;
        page_end_count += predicted.page_end;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      if (char_valid && !taken) begin
        next_valid = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        next_valid = 1'b0;
      end else if (pending_chars.size() > 0) begin
        next_valid = 1'b1;
        next_word = pending_chars[0];
      end else begin
        next_valid = 1'b0;
      end
      char_valid <= next_valid;
      char_word <= next_word;
    end
  end

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Receiver: checks each result word and stalls in changing modes, with two long holds.
  int stall_mode = 0;
  int mode_cycles = 0;
  int hold_left = 0;
  int holds_done = 0;

  always @(posedge clk) begin : result_monitor
    out_word_t want;
    logic      next_stall;
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        $error("result word arrived with nothing expected");
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("glyph_valid", want.glyph_valid, result_word.glyph_valid);
        check_field("glyph_address", want.glyph_address, result_word.glyph_address);
        check_field("draw_x", want.draw_x, result_word.draw_x);
        check_field("draw_y", want.draw_y, result_word.draw_y);
        check_field("bytes_used", want.bytes_used, result_word.bytes_used);
        check_field("page_end", want.page_end, result_word.page_end);
        check_field("code_error", want.code_error, result_word.code_error);
      end
    end
    if (mode_cycles == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_cycles = $urandom_range(16, 64);
    end else begin
      mode_cycles--;
    end
    if (hold_left > 0) begin
      hold_left--;
      next_stall = 1'b1;
    end else if (holds_done < 2 && chars_taken >= (holds_done == 0 ? 200 : 1000)) begin
      hold_left = LONG_HOLD;
      holds_done++;
      next_stall = 1'b1;
    end else begin
      case (stall_mode)
        0: next_stall = 1'b0;
        1: next_stall = ($urandom_range(0, 3) == 0);
        2: next_stall = ($urandom_range(0, 3) != 0);
        default: next_stall = !result_stall;
      endcase
    end
    result_stall <= next_stall;
  end

  task automatic queue_char(logic [7:0] lead, logic [7:0] trail);
    in_word_t c;
    c.lead_byte = lead;
    c.trail_byte = trail;
    pending_chars.push_back(c);
  endtask

  function automatic in_word_t random_char();
    in_word_t c;
    int pick;
    pick = $urandom_range(0, 99);
    c.lead_byte = 8'($urandom_range(0, 255));
    c.trail_byte = 8'($urandom_range(0, 255));
    if (pick < 10) begin
      c.lead_byte = NEWLINE_CODE;
    end else if (pick < 40) begin
      c.lead_byte = 8'($urandom_range(0, 'h9F));
    end else if (pick < 88) begin
      // Well-formed GB2312 pair.
      c.lead_byte = 8'($urandom_range('hA1, 'hF7));
      c.trail_byte = 8'($urandom_range('hA1, 'hFE));
    end else begin
      c.lead_byte = 8'($urandom_range('hA0, 'hFF));
    end
    return c;
  endfunction

  // Sender pause: everything queued has gone in and every result has come back.
  task automatic wait_idle();
    while (pending_chars.size() != 0 || char_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_HOME_X:  margin_left = val;
      CFG_HOME_Y:  margin_top = val[5:0];
      CFG_ROW_GAP: line_gap = val[5:0];
      default: ;
    endcase
  endtask

  initial begin : stimulus
    logic [CfgDataW-1:0] left_val, top_val, gap_val;
    margin_left = HOME_X_RESET;
    margin_top = HOME_Y_RESET;
    line_gap = ROW_GAP_RESET;
    pen_col = 8'(HOME_X_RESET);
    pen_row = 8'(HOME_Y_RESET);
    page_fresh = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset layout.
    queue_char(NEWLINE_CODE, 8'hFF);   // swallowed at the top of the page
    queue_char(8'h00, 8'h00);
    queue_char(8'h20, 8'h55);
    queue_char(8'h41, 8'hAA);
    queue_char(8'h9F, 8'hFF);
    queue_char(NEWLINE_CODE, 8'h00);
    queue_char(NEWLINE_CODE, 8'h00);
    queue_char(8'hA0, 8'h00);          // row zero, negative code point
    queue_char(8'hA1, 8'hA0);          // code point minus one
    queue_char(8'hA1, 8'hA1);
    queue_char(8'hA2, 8'hB1);
    queue_char(8'hA7, 8'hD1);
    queue_char(8'hA8, 8'hA1);          // overlapping segment region starts here
    queue_char(8'hA8, 8'hC4);
    queue_char(8'hA8, 8'hC5);
    queue_char(8'hB0, 8'hA1);
    queue_char(8'hB7, 8'hAF);
    queue_char(8'hFF, 8'h00);
    queue_char(8'hFF, 8'hFF);
    queue_char(8'h7F, 8'h80);
    queue_char(NEWLINE_CODE, 8'h5A);
    queue_char(8'hF7, 8'hFE);
    wait_idle();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin left_val = 7'd0;   top_val = 7'd0;  gap_val = 7'd0;  end
        1: begin left_val = 7'd127; top_val = 7'd63; gap_val = 7'd63; end
        2: begin left_val = 7'd127; top_val = 7'd0;  gap_val = 7'd0;  end
        default: begin
          left_val = 7'($urandom_range(0, 127));
          top_val = 7'($urandom_range(0, 127));
          gap_val = 7'($urandom_range(0, 127));
        end
      endcase
      write_reg(CFG_HOME_X, left_val);
      write_reg(CFG_HOME_Y, top_val);
      write_reg(CFG_ROW_GAP, gap_val);
      if (phase == 3) write_reg(CFG_UNUSED_INDEX, 7'($urandom_range(0, 127)));
      for (int n = 0; n < PHASE_CHARS; n++) pending_chars.push_back(random_char());
      wait_idle();
    end

    repeat (END_DRAIN) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d result words never arrived", expected_results.size());
      mismatches++;
    end
    $display("Covered %0d characters: %0d newlines, %0d half-width, %0d full-width,",
             chars_taken, newline_count, half_count, full_count);
    $display("with %0d code errors and %0d page ends over %0d layout settings.",
             code_error_count, page_end_count, RANDOM_PHASES + 1);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/gbta_pkg.sv
src/gbta_front.sv
src/gbta_queue.sv
src/gbta_back.sv
src/gb2312_text_layout_glyph_addresser_top.sv
src/gbta_checker.sv
tb/gb2312_text_layout_glyph_addresser_top_test.sv
